// ----- hw/rtl/prf_pkg.sv -----
// Shared types and constants for the page replacement block.
// Used by prf_cell and page_replacement_fifo_lru; depends on nothing else.
`default_nettype none

package prf_pkg;

   localparam int MAX_FRAMES = 8;
   localparam int PAGE_BITS  = 16;

   localparam int SLOT_W  = $clog2(MAX_FRAMES);
   localparam int RANK_W  = $clog2(MAX_FRAMES);
   localparam int N_W     = $clog2(MAX_FRAMES + 1);
   localparam int COUNT_W = 16;
   localparam int CFG_W   = 4;
   localparam int CSR_IDX_W = 2;

   // Register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY_MODE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES_IN_USE = CSR_IDX_W'(1);

   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   localparam logic CMD_REF   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Stream packing
   localparam int REQ_W = ((PAGE_BITS + 7) / 8) * 8;

   localparam int RSP_FAULT_LSB = 0;
   localparam int RSP_SLOT_LSB  = 1;
   localparam int RSP_EVV_LSB   = RSP_SLOT_LSB + SLOT_W;
   localparam int RSP_EVP_LSB   = RSP_EVV_LSB + 1;
   localparam int RSP_FTOT_LSB  = RSP_EVP_LSB + PAGE_BITS;
   localparam int RSP_HTOT_LSB  = RSP_FTOT_LSB + COUNT_W;
   localparam int RSP_BITS      = RSP_HTOT_LSB + COUNT_W;
   localparam int RSP_W         = ((RSP_BITS + 7) / 8) * 8;

   // Broadcast from the control to every cell
   typedef struct packed {
      logic                 capture;   // item accepted: latch match flags
      logic                 clear;     // clear item executing
      logic                 update;    // reference item executing
      logic [PAGE_BITS-1:0] page;
      logic [N_W-1:0]       n;         // active frame count at capture
      logic [SLOT_W-1:0]    slot;      // frame that takes the page
      logic [N_W-1:0]       old_rank;  // rank of that frame before the touch
   } cell_ctrl_type;

   // Search results handed from cell to cell
   typedef struct packed {
      logic              hit_found;
      logic [SLOT_W-1:0] hit_idx;
      logic              free_found;
      logic [SLOT_W-1:0] free_idx;
      logic [RANK_W-1:0] best_rank;
      logic [SLOT_W-1:0] best_idx;
   } scan_type;

   // Contents a cell shows to the control
   typedef struct packed {
      logic                 valid;
      logic [RANK_W-1:0]    rank;
      logic [PAGE_BITS-1:0] page;
   } cell_stat_type;

endpackage

`default_nettype wire

// ----- hw/rtl/page_replacement_fifo_lru.sv -----
// Page replacement unit, FIFO or LRU victim choice, built as a chain of frame cells.
// Top level: control, counters and result register. Uses prf_pkg and prf_cell.
//
// Usage:
//   req channel: tuser is the command (reference or clear), tdata the page number.
//   rsp channel: one result item per request item, fields in tdata.
//   csr channel: register 0 policy_mode, register 1 frames_in_use; write only
//   while no item is in flight. csr_ready is always high.
// Timing:
//   An item is accepted, its page compared against every frame in the cycle of
//   acceptance, and in the execute step that follows the frame cells pass hit,
//   free-frame and victim search along the chain, the chosen frame is written,
//   ranks are aged and the result is loaded into the output register, whose valid
//   flag drives rsp_tvalid. No new item is accepted while one is in the execute step.
//   The result register lets the next item be accepted while a result waits.
//   If rsp_tready stays low, the next item holds in the execute step and
//   req_tready stays low until the result register frees up.
// Reset: all frames empty, counters and FIFO pointer zero, FIFO policy,
//   four frames in use. No clearing pass is needed.
`default_nettype none

module page_replacement_fifo_lru
   import prf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request: tuser = {cmd}, tdata = {page_number}
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [REQ_W-1:0]     req_tdata,
   input  wire logic                 req_tuser,
   // result tdata, lowest bit up: fault_flag, frame_slot, evicted_valid,
   // evicted_page, fault_total, hit_total
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata,
   // configuration
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   logic                 policy_ff, policy_in;
   logic [CFG_W-1:0]     frames_ff, frames_in;

   logic                 busy_ff, busy_in;
   logic                 cmd_ff, cmd_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [N_W-1:0]       n_ff, n_in;
   logic [SLOT_W-1:0]    ptr_ff, ptr_in;
   logic [COUNT_W-1:0]   fault_cnt_ff, fault_cnt_in;
   logic [COUNT_W-1:0]   hit_cnt_ff, hit_cnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 o_fault_ff, o_fault_in;
   logic [SLOT_W-1:0]    o_slot_ff, o_slot_in;
   logic                 o_evv_ff, o_evv_in;
   logic [PAGE_BITS-1:0] o_evp_ff, o_evp_in;

   logic [N_W-1:0]       n_cfg;
   logic                 accept;
   logic                 commit;
   logic [SLOT_W-1:0]    ptr_eff;
   logic [SLOT_W-1:0]    slot;
   logic                 evict;
   logic                 hit;
   cell_ctrl_type        ctrl;
   scan_type             scan [MAX_FRAMES+1];
   cell_stat_type        stat [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_vec;

   assign csr_ready  = 1'b1;
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign commit     = busy_ff && (!rsp_valid_ff || rsp_tready);

   // Frame count clamped to 1..MAX_FRAMES
   always_comb begin
      if (frames_ff == '0) begin
         n_cfg = N_W'(1);
      end else if (int'(frames_ff) > MAX_FRAMES) begin
         n_cfg = N_W'(MAX_FRAMES);
      end else begin
         n_cfg = N_W'(frames_ff);
      end
   end

   // Frame cells
   assign scan[0] = '0;
   for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
      prf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (SLOT_W'(g)),
         .ctrl     (ctrl),
         .scan_in  (scan[g]),
         .scan_out (scan[g+1]),
         .stat     (stat[g])
      );
      assign valid_vec[g] = stat[g].valid;
   end

   assign ptr_eff = (N_W'(ptr_ff) >= n_ff) ? '0 : ptr_ff;
   assign hit     = scan[MAX_FRAMES].hit_found;
   assign evict   = !hit && !scan[MAX_FRAMES].free_found;

   always_comb begin
      if (hit) begin
         slot = scan[MAX_FRAMES].hit_idx;
      end else if (scan[MAX_FRAMES].free_found) begin
         slot = scan[MAX_FRAMES].free_idx;
      end else if (policy_ff == POLICY_LRU) begin
         slot = scan[MAX_FRAMES].best_idx;
      end else begin
         slot = ptr_eff;
      end
   end

   always_comb begin
      ctrl.capture  = accept;
      ctrl.clear    = commit && (cmd_ff == CMD_CLEAR);
      ctrl.update   = commit && (cmd_ff == CMD_REF);
      ctrl.page     = accept ? req_tdata[PAGE_BITS-1:0] : page_ff;
      ctrl.n        = n_cfg;
      ctrl.slot     = slot;
      // an empty frame counts as older than every valid one
      ctrl.old_rank = stat[slot].valid ? N_W'(stat[slot].rank) : n_ff;
   end

   always_comb begin
      policy_in    = policy_ff;
      frames_in    = frames_ff;
      busy_in      = busy_ff;
      cmd_in       = cmd_ff;
      page_in      = page_ff;
      n_in         = n_ff;
      ptr_in       = ptr_ff;
      fault_cnt_in = fault_cnt_ff;
      hit_cnt_in   = hit_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      o_fault_in   = o_fault_ff;
      o_slot_in    = o_slot_ff;
      o_evv_in     = o_evv_ff;
      o_evp_in     = o_evp_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POLICY_MODE:   policy_in = csr_wdata[0];
            CSR_FRAMES_IN_USE: frames_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         busy_in = 1'b1;
         cmd_in  = req_tuser;
         page_in = req_tdata[PAGE_BITS-1:0];
         n_in    = n_cfg;
      end

      if (commit) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         if (cmd_ff == CMD_CLEAR) begin
            ptr_in       = '0;
            fault_cnt_in = '0;
            hit_cnt_in   = '0;
            o_fault_in   = 1'b0;
            o_slot_in    = '0;
            o_evv_in     = 1'b0;
            o_evp_in     = '0;
         end else begin
            ptr_in = ptr_eff;
            if (evict && (policy_ff == POLICY_FIFO)) begin
               ptr_in = (N_W'(ptr_eff) + N_W'(1) >= n_ff) ? '0 : ptr_eff + SLOT_W'(1);
            end
            if (hit) begin
               if (hit_cnt_ff != '1) hit_cnt_in = hit_cnt_ff + COUNT_W'(1);
            end else begin
               if (fault_cnt_ff != '1) fault_cnt_in = fault_cnt_ff + COUNT_W'(1);
            end
            o_fault_in = !hit;
            o_slot_in  = slot;
            o_evv_in   = evict;
            o_evp_in   = evict ? stat[slot].page : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POLICY_FIFO;
         frames_ff    <= CFG_W'(4);
         busy_ff      <= 1'b0;
         ptr_ff       <= '0;
         fault_cnt_ff <= '0;
         hit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         policy_ff    <= policy_in;
         frames_ff    <= frames_in;
         busy_ff      <= busy_in;
         ptr_ff       <= ptr_in;
         fault_cnt_ff <= fault_cnt_in;
         hit_cnt_ff   <= hit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      page_ff    <= page_in;
      n_ff       <= n_in;
      o_fault_ff <= o_fault_in;
      o_slot_ff  <= o_slot_in;
      o_evv_ff   <= o_evv_in;
      o_evp_ff   <= o_evp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_FAULT_LSB]                    = o_fault_ff;
      rsp_tdata[RSP_SLOT_LSB +: SLOT_W]           = o_slot_ff;
      rsp_tdata[RSP_EVV_LSB]                      = o_evv_ff;
      rsp_tdata[RSP_EVP_LSB +: PAGE_BITS]         = o_evp_ff;
      rsp_tdata[RSP_FTOT_LSB +: COUNT_W]          = fault_cnt_ff;
      rsp_tdata[RSP_HTOT_LSB +: COUNT_W]          = hit_cnt_ff;
   end

   // Checks
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_tvalid)
      else $error("executed item did not reach the result register");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second item taken while one is executing");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (commit && (cmd_ff == CMD_CLEAR)) |=> (valid_vec == '0))
      else $error("frames still valid after a clear item");

   a_evict_is_fault: assert property (@(posedge clock) disable iff (reset)
      (commit && evict) |-> !hit)
      else $error("eviction chosen on a hit");

endmodule

`default_nettype wire

// ----- hw/rtl/prf_cell.sv -----
// One frame of the page replacement chain: page, valid mark and recency rank.
// Takes the search results from its left neighbor and passes them right. Uses prf_pkg.
`default_nettype none

module prf_cell
   import prf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [SLOT_W-1:0] cell_idx,
   input  wire cell_ctrl_type ctrl,
   input  wire scan_type      scan_in,
   output scan_type           scan_out,
   output cell_stat_type      stat
);

   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 valid_ff, valid_in;
   logic [RANK_W-1:0]    rank_ff, rank_in;
   logic                 match_ff, match_in;
   logic                 active_ff, active_in;

   logic is_slot;
   logic bump;

   assign is_slot = (ctrl.slot == cell_idx);
   assign bump = active_ff && valid_ff && !is_slot
              && (N_W'(rank_ff) < ctrl.old_rank)
              && (N_W'(rank_ff) < N_W'(MAX_FRAMES - 1));

   always_comb begin
      page_in   = page_ff;
      valid_in  = valid_ff;
      rank_in   = rank_ff;
      match_in  = match_ff;
      active_in = active_ff;
      if (ctrl.capture) begin
         active_in = (N_W'(cell_idx) < ctrl.n);
         match_in  = valid_ff && (page_ff == ctrl.page) && (N_W'(cell_idx) < ctrl.n);
      end
      if (ctrl.clear) begin
         valid_in = 1'b0;
         rank_in  = '0;
      end else if (ctrl.update) begin
         if (is_slot) begin
            page_in  = ctrl.page;
            valid_in = 1'b1;
            rank_in  = '0;
         end else if (bump) begin
            rank_in = rank_ff + RANK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         rank_ff   <= '0;
         match_ff  <= 1'b0;
         active_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rank_ff   <= rank_in;
         match_ff  <= match_in;
         active_ff <= active_in;
      end
      page_ff <= page_in;
   end

   // First match, first free frame, lowest frame with the highest rank
   always_comb begin
      scan_out = scan_in;
      if (!scan_in.hit_found && match_ff) begin
         scan_out.hit_found = 1'b1;
         scan_out.hit_idx   = cell_idx;
      end
      if (!scan_in.free_found && active_ff && !valid_ff) begin
         scan_out.free_found = 1'b1;
         scan_out.free_idx   = cell_idx;
      end
      if (active_ff && (rank_ff > scan_in.best_rank)) begin
         scan_out.best_rank = rank_ff;
         scan_out.best_idx  = cell_idx;
      end
   end

   assign stat.valid = valid_ff;
   assign stat.rank  = rank_ff;
   assign stat.page  = page_ff;

endmodule

`default_nettype wire

// ----- dv/tb_page_replacement_fifo_lru.sv -----
// Self-checking bench for page_replacement_fifo_lru: directed references and
// random phases over both policies and frame counts 0, 1, 2, 3, 5, 8 and 15.
// Depends on prf_pkg and the RTL of the block only.
`timescale 1ns / 100ps

typedef struct {
   bit                              fault;
   bit [prf_pkg::SLOT_W-1:0]        slot;
   bit                              ev_valid;
   bit [prf_pkg::PAGE_BITS-1:0]     ev_page;
   bit [prf_pkg::COUNT_W-1:0]       faults;
   bit [prf_pkg::COUNT_W-1:0]       hits;
} frame_outcome_type;

class frame_scoreboard;
   bit                            policy;
   bit [prf_pkg::CFG_W-1:0]       frames_cfg;
   bit [prf_pkg::PAGE_BITS-1:0]   pages [prf_pkg::MAX_FRAMES];
   bit                            valid [prf_pkg::MAX_FRAMES];
   int                            rank  [prf_pkg::MAX_FRAMES];
   int                            fifo_ptr;
   bit [prf_pkg::COUNT_W-1:0]     fault_count;
   bit [prf_pkg::COUNT_W-1:0]     hit_count;
   frame_outcome_type             pending_outcomes[$];
   int                            mismatches;

   function new();
      policy     = prf_pkg::POLICY_FIFO;
      frames_cfg = 4;
      mismatches = 0;
      clear_frames();
   endfunction

   function void clear_frames();
      for (int i = 0; i < prf_pkg::MAX_FRAMES; i++) begin
         pages[i] = '0;
         valid[i] = 1'b0;
         rank[i]  = 0;
      end
      fifo_ptr    = 0;
      fault_count = '0;
      hit_count   = '0;
   endfunction

   function void write_register(bit [prf_pkg::CSR_IDX_W-1:0] idx,
                                bit [prf_pkg::CFG_W-1:0] val);
      if (idx == prf_pkg::CSR_POLICY_MODE)
         policy = val[0];
      else if (idx == prf_pkg::CSR_FRAMES_IN_USE)
         frames_cfg = val;
   endfunction

   // make frame s the most recent among the active frames, aging the younger ones
   function void promote(int s, int n);
      int old_rank;
      old_rank = valid[s] ? rank[s] : n;
      for (int i = 0; i < n; i++)
         if (i != s && valid[i] && rank[i] < old_rank && rank[i] < prf_pkg::MAX_FRAMES - 1)
            rank[i]++;
      rank[s] = 0;
   endfunction

   function frame_outcome_type resolve_reference(bit cmd, bit [prf_pkg::PAGE_BITS-1:0] page);
      frame_outcome_type r;
      int n, slot, best;
      bit found, free_found;
      r = '{default: 0};
      slot = 0;
      if (frames_cfg == 0)
         n = 1;
      else if (frames_cfg > prf_pkg::MAX_FRAMES)
         n = prf_pkg::MAX_FRAMES;
      else
         n = frames_cfg;
      if (cmd == prf_pkg::CMD_CLEAR) begin
         clear_frames();
      end else begin
         if (fifo_ptr >= n)
            fifo_ptr = 0;
         found = 1'b0;
         for (int i = 0; i < n; i++)
            if (!found && valid[i] && pages[i] == page) begin
               slot  = i;
               found = 1'b1;
            end
         if (found) begin
            if (hit_count != '1)
               hit_count++;
         end else begin
            r.fault = 1'b1;
            if (fault_count != '1)
               fault_count++;
            free_found = 1'b0;
            for (int i = 0; i < n; i++)
               if (!free_found && !valid[i]) begin
                  slot       = i;
                  free_found = 1'b1;
               end
            if (!free_found) begin
               if (policy == prf_pkg::POLICY_FIFO) begin
                  slot     = fifo_ptr;
                  fifo_ptr = (fifo_ptr + 1 >= n) ? 0 : fifo_ptr + 1;
               end else begin
                  // lowest frame wins a tie on the oldest rank
                  best = 0;
                  for (int i = 0; i < n; i++)
                     if (rank[i] > best) begin
                        best = rank[i];
                        slot = i;
                     end
               end
               r.ev_valid = 1'b1;
               r.ev_page  = pages[slot];
            end
         end
         promote(slot, n);
         pages[slot] = page;
         valid[slot] = 1'b1;
      end
      r.slot   = slot;
      r.faults = fault_count;
      r.hits   = hit_count;
      return r;
   endfunction

   function void note_request(bit cmd, bit [prf_pkg::PAGE_BITS-1:0] page);
      pending_outcomes = {pending_outcomes, resolve_reference(cmd, page)};
   endfunction

   function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      end
   endfunction

   function void check_result(bit [prf_pkg::RSP_W-1:0] d);
      frame_outcome_type e;
      if (pending_outcomes.size() == 0) begin
         mismatches++;
         $error("result item with no request pending: 0x%0h", d);
         return;
      end
      e = pending_outcomes.pop_front();
      compare_field("fault_flag", e.fault, d[prf_pkg::RSP_FAULT_LSB]);
      compare_field("frame_slot", e.slot, d[prf_pkg::RSP_SLOT_LSB +: prf_pkg::SLOT_W]);
      compare_field("evicted_valid", e.ev_valid, d[prf_pkg::RSP_EVV_LSB]);
      compare_field("evicted_page", e.ev_page, d[prf_pkg::RSP_EVP_LSB +: prf_pkg::PAGE_BITS]);
      compare_field("fault_total", e.faults, d[prf_pkg::RSP_FTOT_LSB +: prf_pkg::COUNT_W]);
      compare_field("hit_total", e.hits, d[prf_pkg::RSP_HTOT_LSB +: prf_pkg::COUNT_W]);
   endfunction
endclass

module tb_page_replacement_fifo_lru;
   import prf_pkg::*;

   localparam int CYCLE_LIMIT = 1_500_000;

   typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 req_tuser  = CMD_REF;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]     csr_wdata  = '0;

   frame_scoreboard sb = new();

   int          cycle_count = 0;
   bit          no_gaps     = 1'b0;
   int          burst_left  = 0;
   rx_mode_type rx_mode     = RX_STREAM;
   int          mode_left   = 0;
   int          stall_left  = 0;

   page_replacement_fifo_lru dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_page_replacement_fifo_lru: errors");
         $finish;
      end
   end

   // handshake monitors
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_request(req_tuser, req_tdata[PAGE_BITS-1:0]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
      if (!reset && csr_valid && csr_ready)
         sb.write_register(csr_index, csr_wdata);
   end

   // receiver back-pressure, switching between a few stall styles
   always @(negedge clock) begin
      if (mode_left == 0) begin
         rx_mode   = rx_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(40, 300);
      end else begin
         mode_left--;
      end
      case (rx_mode)
         RX_STREAM: rsp_tready <= 1'b1;
         RX_COIN:   rsp_tready <= $urandom_range(0, 1);
         RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 5) == 0)
                  stall_left = $urandom_range(1, 24);
            end
         end
      endcase
   end

   function automatic int next_gap();
      if (no_gaps)
         return 0;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      burst_left = $urandom_range(0, 24);
      return ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 4);
   endfunction

   // valid stays high after the accept; the gap decides whether it drops
   task automatic send_item(input logic cmd, input logic [PAGE_BITS-1:0] page);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_W'(page);
      do @(posedge clock); while (!req_tready);
      gap = next_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one setting: working-set references with drift, near misses and rare clears
   task automatic run_phase(input logic [CFG_W-1:0] frames, input int count);
      logic [PAGE_BITS-1:0] hot[$];
      logic [PAGE_BITS-1:0] page;
      int pick, set_size;
      wait_idle();
      write_csr(CSR_POLICY_MODE, CFG_W'($urandom_range(0, 15)));
      write_csr(CSR_FRAMES_IN_USE, frames);
      no_gaps  = ($urandom_range(0, 3) == 0);
      set_size = $urandom_range(1, 12);
      for (int i = 0; i < set_size; i++)
         hot = {hot, PAGE_BITS'($urandom_range(0, 65535))};
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         page = hot[$urandom_range(0, hot.size() - 1)];
         if (pick < 2) begin
            send_item(CMD_CLEAR, PAGE_BITS'($urandom_range(0, 65535)));
         end else if (pick < 80) begin
            send_item(CMD_REF, page);
         end else if (pick < 92) begin
            page = PAGE_BITS'($urandom_range(0, 65535));
            hot[$urandom_range(0, hot.size() - 1)] = page;
            send_item(CMD_REF, page);
         end else if (pick < 97) begin
            // one bit off a page from the hot set
            send_item(CMD_REF, page ^ (PAGE_BITS'(1) << $urandom_range(0, PAGE_BITS - 1)));
         end else begin
            send_item(CMD_REF, $urandom_range(0, 1) ? '1 : '0);
         end
      end
   endtask

   initial begin
      logic [CFG_W-1:0] phase_frames[8];

      phase_frames = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd3, 4'd8, 4'd2};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // FIFO, four frames from reset: fill, hit, evictions in FIFO order, clear
      send_item(CMD_REF, 16'h0000);
      send_item(CMD_REF, 16'hFFFF);
      send_item(CMD_REF, 16'h0000);
      send_item(CMD_REF, 16'h1234);
      send_item(CMD_REF, 16'h8001);
      send_item(CMD_REF, 16'h5555);
      send_item(CMD_REF, 16'hFFFF);
      send_item(CMD_REF, 16'h0000);
      send_item(CMD_CLEAR, 16'hAAAA);
      send_item(CMD_REF, 16'h0000);   // empty frames must not match page zero
      wait_idle();

      // LRU on three frames
      write_csr(CSR_POLICY_MODE, CFG_W'(POLICY_LRU));
      write_csr(CSR_FRAMES_IN_USE, 4'd3);
      send_item(CMD_REF, 16'h0001);
      send_item(CMD_REF, 16'h0002);
      send_item(CMD_REF, 16'h0000);
      send_item(CMD_REF, 16'h0003);
      send_item(CMD_REF, 16'h0002);
      send_item(CMD_REF, 16'h0004);
      wait_idle();

      // count of zero acts as one frame
      write_csr(CSR_FRAMES_IN_USE, 4'd0);
      send_item(CMD_REF, 16'h0004);
      send_item(CMD_REF, 16'h0007);
      send_item(CMD_REF, 16'h0007);
      wait_idle();

      // count above the maximum acts as eight; upper frames kept their pages
      write_csr(CSR_POLICY_MODE, CFG_W'(POLICY_FIFO));
      write_csr(CSR_FRAMES_IN_USE, 4'd15);
      send_item(CMD_REF, 16'h0003);
      send_item(CMD_REF, 16'h0009);
      send_item(CMD_REF, 16'hFFFE);
      wait_idle();

      for (int p = 0; p < 8; p++)
         run_phase(phase_frames[p], 230);

      wait_idle();
      if (sb.mismatches == 0 && sb.pending_outcomes.size() == 0)
         $display("tb_page_replacement_fifo_lru: clean");
      else
         $display("tb_page_replacement_fifo_lru: errors");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/prf_pkg.sv
hw/rtl/prf_cell.sv
hw/rtl/page_replacement_fifo_lru.sv
dv/tb_page_replacement_fifo_lru.sv
